FILE: rtl/bde_pkg.sv
// Package for the bounding-box distance estimator.
// Shared types, opcodes, status and basis codes. No dependencies.
package bde_pkg;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOREF   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [1:0] BASIS_AVG = 2'd0;
	localparam logic [1:0] BASIS_W   = 2'd1;
	localparam logic [1:0] BASIS_H   = 2'd2;

	localparam logic [7:0] WILDCARD = 8'hFF;
	localparam int ENTRY_W = 48;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_RDHIT, S_LOAD, S_MUL, S_DIVW, S_DIVH, S_FINISH, S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [39:0] num;
		logic [23:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [39:0] quo;
	} div_rsp_t;

endpackage

FILE: rtl/bde_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module bde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/bde_div.sv
// Restoring divider, one quotient bit per cycle, 40-bit by 24-bit.
// Depends on bde_pkg.
module bde_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bde_pkg::div_req_t  req,
	output bde_pkg::div_rsp_t  rsp
);
	import bde_pkg::*;

	logic [39:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] trial;

	assign trial = {rem_q, quo_q[39]};
	assign rsp = {done_q, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
				quo_q <= req.num;
				rem_q <= '0;
				den_q <= req.den;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= 24'(trial - {1'b0, den_q});
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= trial[23:0];
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: rtl/bbox_distance_estimator_top.sv
// Top level of the bounding-box distance estimator.
// Depends on bde_pkg, bde_ram, bde_div.

// One item at a time. For add, clear and the unused opcode, m_tvalid rises
// once the item has passed S_SCAN, which loads the output register. A query
// scans the reference table one entry per cycle through the table RAM's read
// port, loads the entry and forms the products, then runs two 40-bit divisions
// on the shared serial divider and picks the result. The result sits in an
// output register; the next item is taken once that register is free.
module bbox_distance_estimator_top #(
	parameter int MAX_REFS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	// obj_class[7:0], ref_width[27:8], ref_height[47:28],
	// box_width[63:48], box_height[79:64]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// distance[31:0], status[33:32], basis[35:34]
	output logic [39:0] m_tdata
);
	import bde_pkg::*;

	localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CW = $clog2(MAX_REFS + 1);

	state_t state_q, state_d;
	logic [19:0] focal_q;
	logic [CW-1:0] count_q;
	logic [81:0] item_q;
	logic [CW:0] idx_q;
	logic [AW-1:0] hit_q;
	logic found_q, wild_q;
	logic [39:0] pw_q, ph_q, dw_q;
	logic [36:0] lhs_q, rhs1_q;
	logic [31:0] dist_out;
	logic [1:0] st_out, bs_out;
	logic out_load;
	logic [39:0] out_q;
	logic outv_q;

	logic [1:0]  op;
	logic [7:0]  cls;
	logic [19:0] rw, rh;
	logic [15:0] bw, bh;
	assign op  = item_q[1:0];
	assign cls = item_q[9:2];
	assign rw  = item_q[29:10];
	assign rh  = item_q[49:30];
	assign bw  = item_q[65:50];
	assign bh  = item_q[81:66];

	logic ram_we;
	logic [AW-1:0] ram_ra;
	logic [ENTRY_W-1:0] ram_rd;
	logic [7:0] rd_cls;

	bde_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REFS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(count_q[AW-1:0]),
		.wdata({(rh != 20'd0) ? rh : rw, rw, cls}),
		.raddr(ram_ra), .rdata(ram_rd)
	);
	assign rd_cls = ram_rd[7:0];

	div_req_t dreq;
	div_rsp_t drsp;
	bde_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (state_q == S_IDLE) && !outv_q;
	assign m_tvalid = outv_q;
	assign m_tdata = out_q;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_ra = idx_q[AW-1:0];
		dreq = '0;
		out_load = 1'b0;
		dist_out = '0;
		st_out = ST_DONE;
		bs_out = BASIS_AVG;
		unique case (state_q)
			S_IDLE: if (s_tvalid && s_tready) state_d = S_SCAN;
			S_SCAN: begin
				ram_ra = '0;
				priority if (op == OP_ADD) begin
					out_load = 1'b1;
					if (count_q >= CW'(MAX_REFS)) st_out = ST_FULL;
					else if (rw == 20'd0) st_out = ST_INVALID;
					else ram_we = 1'b1;
					state_d = S_IDLE;
				end else if (op != OP_QUERY) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end else if (count_q == '0 || bw == 16'd0 || bh == 16'd0) begin
					out_load = 1'b1;
					st_out = ST_NOREF;
					state_d = S_IDLE;
				end else begin
					state_d = S_RDHIT;
				end
			end
			S_RDHIT: begin
				// rd data is entry idx_q-1 in flight; evaluated in sequential block
				if (found_q) begin
					ram_ra = hit_q;
					state_d = S_LOAD;
				end else if (idx_q > {1'b0, count_q}) begin
					if (wild_q) begin
						ram_ra = hit_q;
						state_d = S_LOAD;
					end else begin
						out_load = 1'b1;
						st_out = ST_NOREF;
						state_d = S_IDLE;
					end
				end
			end
			S_LOAD: state_d = S_MUL;
			S_MUL: begin
				dreq.start = 1'b1;
				dreq.num = pw_q;
				dreq.den = {bw, 8'd0};
				state_d = S_DIVW;
			end
			S_DIVW: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = ph_q;
				dreq.den = {bh, 8'd0};
				state_d = S_DIVH;
			end
			S_DIVH: if (drsp.done) state_d = S_FINISH;
			S_FINISH: begin
				out_load = 1'b1;
				if (lhs_q > {rhs1_q, 1'b0} + {1'b0, rhs1_q}) begin
					dist_out = dw_q[31:0];
					bs_out = BASIS_H;
				end else if (lhs_q < rhs1_q) begin
					dist_out = pw_q[31:0];
					bs_out = BASIS_W;
				end else begin
					dist_out = 32'((({1'b0, pw_q}) + {1'b0, dw_q}) >> 1);
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= 20'd128000;
			count_q <= '0;
			outv_q <= 1'b0;
		end else begin
			if (cfg_we) focal_q <= cfg_wdata;
			if (m_tvalid && m_tready) outv_q <= 1'b0;
			if (out_load) outv_q <= 1'b1;
			if (ram_we) count_q <= count_q + CW'(1);
			if (state_q == S_SCAN && op == OP_CLEAR) count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_q <= {s_tdata, s_tuser};
		if (out_load) out_q <= {4'd0, bs_out, st_out, dist_out};
		unique case (state_q)
			S_SCAN: begin
				idx_q <= (CW+1)'(1);
				found_q <= 1'b0;
				wild_q <= 1'b0;
			end
			S_RDHIT: if (!found_q && idx_q <= {1'b0, count_q}) begin
				if (rd_cls == cls) begin
					found_q <= 1'b1;
					hit_q <= AW'(idx_q - (CW+1)'(1));
				end else if (rd_cls == WILDCARD) begin
					wild_q <= 1'b1;
					hit_q <= AW'(idx_q - (CW+1)'(1));
				end
				idx_q <= idx_q + (CW+1)'(1);
			end
			S_LOAD: begin
				pw_q <= focal_q * ram_rd[27:8];
				ph_q <= focal_q * ram_rd[47:28];
				lhs_q <= {bw, 1'b0} * ram_rd[47:28];
				rhs1_q <= ram_rd[27:8] * bh;
			end
			S_DIVW: if (drsp.done) pw_q <= drsp.quo;
			S_DIVH: if (drsp.done) dw_q <= drsp.quo;
			default: ;
		endcase
	end
endmodule

FILE: verif/bde_checker.sv
// Checker for the bounding-box distance estimator: tracks the reference table
// and focal length, predicts each result and compares it. Depends on bde_pkg.
`timescale 1ns / 100ps

module bde_checker #(
	parameter int MAX_REFS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [79:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	import bde_pkg::*;

	typedef struct packed {
		logic [1:0]  basis;
		logic [1:0]  status;
		logic [31:0] distance;
	} estimate_t;

	logic [19:0] focal;
	int          n_refs;
	logic [7:0]  ref_cls [MAX_REFS];
	logic [19:0] ref_w   [MAX_REFS];
	logic [19:0] ref_h   [MAX_REFS];
	estimate_t   estimates_due[$];

	assign pending = estimates_due.size();

	function automatic logic [63:0] pinhole(logic [63:0] sz, logic [63:0] px);
		return ({44'd0, focal} * sz) / (px * 64'd256);
	endfunction

	task automatic estimate(input logic [81:0] d);
		logic [1:0]  op;
		logic [7:0]  cls;
		logic [19:0] rw, rh;
		logic [63:0] bw, bh, w, h, dw, dh, est, lhs;
		int          hit, wild;
		estimate_t   e;
		op = d[1:0];
		cls = d[9:2];
		rw = d[29:10];
		rh = d[49:30];
		bw = {48'd0, d[65:50]};
		bh = {48'd0, d[81:66]};
		e = '0;
		if (op == OP_ADD) begin
			if (n_refs >= MAX_REFS) e.status = ST_FULL;
			else if (rw == 0) e.status = ST_INVALID;
			else begin
				ref_cls[n_refs] = cls;
				ref_w[n_refs] = rw;
				ref_h[n_refs] = (rh != 0) ? rh : rw;
				n_refs++;
			end
		end else if (op == OP_CLEAR) begin
			n_refs = 0;
		end else if (op == OP_QUERY) begin
			hit = -1;
			wild = -1;
			for (int i = 0; i < n_refs; i++) begin
				if (ref_cls[i] == cls) begin
					hit = i;
					break;
				end
				if (ref_cls[i] == WILDCARD) wild = i;
			end
			if (hit < 0) hit = wild;
			if (hit < 0 || bw == 0 || bh == 0) e.status = ST_NOREF;
			else begin
				w = {44'd0, ref_w[hit]};
				h = {44'd0, ref_h[hit]};
				dw = pinhole(w, bw);
				dh = pinhole(h, bh);
				lhs = 2 * bw * h;
				if (lhs > 3 * w * bh) begin
					est = dh;
					e.basis = BASIS_H;
				end else if (lhs < w * bh) begin
					est = dw;
					e.basis = BASIS_W;
				end else begin
					est = (dw + dh) / 2;
					e.basis = BASIS_AVG;
				end
				e.distance = (est > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : est[31:0];
				e.status = ST_DONE;
			end
		end
		estimates_due.push_back(e);
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		estimate_t exp_e, got;
		int errs;
		if (!arst_n) begin
			focal <= 20'd128000;
			n_refs = 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (cfg_we) focal <= cfg_wdata;
			if (s_tvalid && s_tready) estimate({s_tdata, s_tuser});
			if (m_tvalid && m_tready) begin
				got = m_tdata[35:0];
				if (estimates_due.size() == 0) begin
					$error("unexpected item %h", got);
					errs++;
				end else begin
					exp_e = estimates_due.pop_front();
					if (got.distance !== exp_e.distance) begin
						$error("distance exp %0d got %0d", exp_e.distance, got.distance);
						errs++;
					end
					if (got.status !== exp_e.status) begin
						$error("status exp %0d got %0d", exp_e.status, got.status);
						errs++;
					end
					if (got.basis !== exp_e.basis) begin
						$error("basis exp %0d got %0d", exp_e.basis, got.basis);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: verif/tb_top.sv
// Testbench top for bbox_distance_estimator_top: stimulus, idling phases,
// watchdog and verdict. Depends on bde_pkg, bde_checker and the RTL.
`timescale 1ns / 100ps

module tb_top;
	import bde_pkg::*;

	localparam int MAX_REFS = 16;
	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [19:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_req;
	logic        hold_taken = 1'b0;
	int          hold_off = 0;
	int          quiet_cycles = 0;

	bbox_distance_estimator_top #(.MAX_REFS(MAX_REFS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	bde_checker #(.MAX_REFS(MAX_REFS)) checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_off <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("[bbox_distance_estimator_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] cls,
			input logic [19:0] rw, input logic [19:0] rh,
			input logic [15:0] bw, input logic [15:0] bh);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {bh, bw, rh, rw, cls};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle_and_config(input logic [19:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [19:0] rand_size();
		unique case ($urandom_range(3))
			0: return 20'($urandom_range(1, 255));
			1: return 20'($urandom_range(1, 20000));
			2: return 20'hFFFFF;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_box();
		unique case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 64));
			default: return 16'($urandom_range(1, 2000));
		endcase
	endfunction

	task automatic random_item();
		logic [7:0] cls;
		int k;
		cls = ($urandom_range(4) == 0) ? WILDCARD : 8'($urandom_range(7));
		if ($urandom_range(9) == 0) cls = 8'($urandom);
		k = $urandom_range(99);
		if (k < 30)
			send_item(OP_ADD, cls, ($urandom_range(19) == 0) ? 20'd0 : rand_size(),
				($urandom_range(3) == 0) ? 20'd0 : rand_size(), 16'($urandom), 16'($urandom));
		else if (k < 34)
			send_item(OP_CLEAR, cls, 20'($urandom), 20'($urandom), 16'($urandom),
				16'($urandom));
		else if (k < 37)
			send_item(OP_RSVD, cls, 20'($urandom), 20'($urandom), 16'($urandom),
				16'($urandom));
		else
			send_item(OP_QUERY, cls, 20'($urandom), 20'($urandom), rand_box(), rand_box());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset focal length, edge cases
		send_item(OP_QUERY, 8'd1, 20'd0, 20'd0, 16'd10, 16'd10);
		send_item(OP_ADD, 8'd1, 20'd0, 20'd5, 16'd0, 16'd0);
		send_item(OP_ADD, 8'd1, 20'd1600, 20'd0, 16'd0, 16'd0);
		send_item(OP_ADD, 8'd2, 20'd1000, 20'd4000, 16'd0, 16'd0);
		send_item(OP_ADD, 8'd255, 20'hFFFFF, 20'hFFFFF, 16'd0, 16'd0);
		send_item(OP_QUERY, 8'd1, 20'd0, 20'd0, 16'd40, 16'd40);
		send_item(OP_QUERY, 8'd2, 20'd0, 20'd0, 16'd100, 16'd100);
		send_item(OP_QUERY, 8'd2, 20'd0, 20'd0, 16'd10, 16'd400);
		send_item(OP_QUERY, 8'd2, 20'd0, 20'd0, 16'd50, 16'd200);
		send_item(OP_QUERY, 8'd77, 20'd0, 20'd0, 16'd1, 16'd1);
		send_item(OP_QUERY, 8'd1, 20'd0, 20'd0, 16'd0, 16'd5);
		send_item(OP_QUERY, 8'd1, 20'd0, 20'd0, 16'hFFFF, 16'hFFFF);
		send_item(OP_RSVD, 8'hFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 14; i++)
			send_item(OP_ADD, 8'd9, 20'd100, 20'd100, 16'd0, 16'd0);
		send_item(OP_CLEAR, 8'd0, 20'd0, 20'd0, 16'd0, 16'd0);
		send_item(OP_QUERY, 8'd255, 20'd0, 20'd0, 16'd1, 16'd1);

		settle_and_config(20'hFFFFF);
		send_item(OP_ADD, 8'd255, 20'hFFFFF, 20'd0, 16'd0, 16'd0);
		send_item(OP_QUERY, 8'd3, 20'd0, 20'd0, 16'd1, 16'd1);

		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 79; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 79; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			unique case (ph)
				1: settle_and_config(20'd0);
				2: settle_and_config(20'd256);
				3: settle_and_config(20'($urandom));
				4: settle_and_config(20'd128000);
				default: ;
			endcase
			if (ph == 0) hold_req = 1'b1;
			for (int n = 0; n < 105; n++) random_item();
		end

		s_tvalid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("[bbox_distance_estimator_top] OK");
		else
			$display("[bbox_distance_estimator_top] ERROR");
		$finish;
	end

endmodule
